// ===== sv/led_pattern_sequencer_core_defines.svh =====
// Assertion macros shared by the LED pattern sequencer RTL.
`ifndef LED_PATTERN_SEQUENCER_CORE_DEFINES_SVH
`define LED_PATTERN_SEQUENCER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lps_pkg.sv =====
// Shared types and codes of the LED pattern sequencer.
package lps_pkg;

  // Default sizes.
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int LEVEL_BITS_DEF  = 16;
  // Upper bound on entries walked in one step event.
  localparam int WALK_LIMIT_MAX  = 16;

  // Request operations.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Step entry kinds; the unused code behaves as a fade.
  localparam logic [1:0] KIND_SET  = 2'd0;
  localparam logic [1:0] KIND_HOLD = 2'd1;
  localparam logic [1:0] KIND_FADE = 2'd2;

  // Output command codes.
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_FADE = 1'b1;

  // One request.
  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         entry_index;
    logic [1:0]         step_kind;
    logic [15:0]        step_level;
    logic [15:0]        step_duration;
    logic [4:0]         run_length;
    logic signed [15:0] extra_passes;
    logic [15:0]        final_level_in;
  } item_t;

  // One output command.
  typedef struct packed {
    logic        command;
    logic [15:0] out_level;
    logic [15:0] fade_millis;
    logic        last;
  } out_t;

  // Command handed from the engine to the output register.
  typedef struct packed {
    logic valid;
    out_t item;
  } push_t;

endpackage

// ===== sv/led_pattern_sequencer_core.sv =====
// Top level of the LED pattern sequencer: request port, engine and command register.
//
//   Channel  Signals                       Direction  Contents
//   item     item_valid, item_stall, item  in         load, start or tick request
//   cmd      cmd_valid, cmd_stall, cmd     out        set or fade command
//
// A load, or a tick that does not end a wait, leaves the engine idle.
// A step event walks the step table entry by entry through its single read port,
// stops at a delay, the run end or the walk limit, and hands over its last
// command from the flush state.
// Reset clears the run registers; table entries hold nothing until loaded.
// A held cmd_stall pauses the walk once output and pending registers are both full.
module led_pattern_sequencer_core #(
  parameter int TableDepth = lps_pkg::TABLE_DEPTH_DEF,
  parameter int LevelBits  = lps_pkg::LEVEL_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  lps_pkg::item_t item,
  output logic           cmd_valid,
  input  logic           cmd_stall,
  output lps_pkg::out_t  cmd
);

  logic           busy;
  logic           in_accept;
  logic           push_ready;
  lps_pkg::push_t push;

  // Requests are taken only while the engine is idle.
  assign item_stall = busy;
  assign in_accept  = item_valid && !busy;

  lps_engine #(
    .TableDepth (TableDepth),
    .LevelBits  (LevelBits)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_accept  (in_accept),
    .in_item    (item),
    .busy       (busy),
    .push       (push),
    .push_ready (push_ready)
  );

  // Output register: free when empty or when its command is taken this cycle.
  assign push_ready = !cmd_valid || !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (push.valid && push_ready) begin
      cmd_valid <= 1'b1;
    end else if (!cmd_stall) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid && push_ready) begin
      cmd <= push.item;
    end
  end

endmodule

// ===== sv/lps_engine.sv =====
// Step table memory and walk sequencer of the LED pattern sequencer.
module lps_engine #(
  parameter int TableDepth = lps_pkg::TABLE_DEPTH_DEF,
  parameter int LevelBits  = lps_pkg::LEVEL_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_accept,
  input  lps_pkg::item_t in_item,
  output logic           busy,
  output lps_pkg::push_t push,
  input  logic           push_ready
);

  localparam int AW = $clog2(TableDepth);
  localparam int PW = $clog2(TableDepth + 1);
  localparam int WalkLimit = (TableDepth < lps_pkg::WALK_LIMIT_MAX) ?
                             TableDepth : lps_pkg::WALK_LIMIT_MAX;
  localparam int DW = $clog2(WalkLimit + 1);
  localparam int EW = 2 + LevelBits + 16;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]           state, state_next;
  logic [PW-1:0]        position, position_next;
  logic [PW-1:0]        active_length, active_length_next;
  logic [15:0]          passes_left, passes_left_next;
  logic [LevelBits-1:0] final_level, final_level_next;
  logic [15:0]          wait_countdown, wait_countdown_next;
  logic                 waiting, waiting_next;
  logic [DW-1:0]        done_count, done_count_next;
  logic                 pend_valid, pend_valid_next;
  lps_pkg::out_t        pend_item, pend_item_next;

  logic [EW-1:0]        table_mem [TableDepth];
  logic [EW-1:0]        rd_data;
  logic [AW-1:0]        rd_addr;
  logic                 load_en;

  logic [1:0]           e_kind;
  logic [LevelBits-1:0] e_level;
  logic [15:0]          e_dur;
  logic [PW-1:0]        len_sat;

  assign e_kind  = rd_data[EW-1 -: 2];
  assign e_level = rd_data[16 +: LevelBits];
  assign e_dur   = rd_data[15:0];
  assign busy    = (state != S_IDLE);

  // A run length beyond the table saturates to the table depth.
  assign len_sat = (32'(in_item.run_length) > TableDepth) ?
                   PW'(TableDepth) : PW'(in_item.run_length);

  // The table is read every cycle at the position the sequencer holds next.
  assign rd_addr = (32'(position_next) < TableDepth) ? AW'(position_next) : '0;
  assign load_en = in_accept && (in_item.operation == lps_pkg::OP_LOAD) &&
                   (32'(in_item.entry_index) < TableDepth);

  // Step table: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (load_en) begin
      table_mem[AW'(in_item.entry_index)] <= {in_item.step_kind,
                                              in_item.step_level[LevelBits-1:0],
                                              in_item.step_duration};
    end
    rd_data <= table_mem[rd_addr];
  end

  // Sequencer: request decode, one entry per unheld walk cycle, final flush.
  always_comb begin
    lps_pkg::out_t new_item;
    logic          at_end;
    logic          at_limit;
    logic          emits;
    logic          hold;
    logic [15:0]   delay;
    logic [PW-1:0] pos_inc;

    state_next          = state;
    position_next       = position;
    active_length_next  = active_length;
    passes_left_next    = passes_left;
    final_level_next    = final_level;
    wait_countdown_next = wait_countdown;
    waiting_next        = waiting;
    done_count_next     = done_count;
    pend_valid_next     = pend_valid;
    pend_item_next      = pend_item;
    push.valid          = 1'b0;
    push.item           = pend_item;
    push.item.last      = 1'b0;

    at_end   = (position >= active_length);
    at_limit = (32'(done_count) >= WalkLimit);
    pos_inc  = position + PW'(1);
    delay    = '0;
    emits    = 1'b0;
    hold     = 1'b0;
    new_item.command     = lps_pkg::CMD_SET;
    new_item.out_level   = 16'(final_level);
    new_item.fade_millis = '0;
    new_item.last        = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (in_item.operation)
            lps_pkg::OP_START: begin
              active_length_next = len_sat;
              passes_left_next   = in_item.extra_passes;
              final_level_next   = in_item.final_level_in[LevelBits-1:0];
              position_next      = '0;
              done_count_next    = '0;
              if (len_sat != '0 && !waiting) begin
                state_next = S_WALK;
              end else begin
                // Start over a pending wait or an empty run: final level only.
                pend_item_next.command     = lps_pkg::CMD_SET;
                pend_item_next.out_level   = 16'(in_item.final_level_in[LevelBits-1:0]);
                pend_item_next.fade_millis = '0;
                pend_item_next.last        = 1'b0;
                pend_valid_next            = 1'b1;
                state_next                 = S_FLUSH;
              end
            end
            lps_pkg::OP_TICK: begin
              if (waiting) begin
                if (wait_countdown != '0) begin
                  wait_countdown_next = wait_countdown - 16'd1;
                end
                if (wait_countdown <= 16'd1) begin
                  waiting_next    = 1'b0;
                  done_count_next = '0;
                  state_next      = S_WALK;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_WALK: begin
        // Decide what the current entry produces.
        if (at_end) begin
          emits = 1'b1;
        end else if (!at_limit) begin
          case (e_kind)
            lps_pkg::KIND_SET: begin
              emits              = 1'b1;
              new_item.out_level = 16'(e_level);
            end
            lps_pkg::KIND_HOLD: begin
              delay = e_dur;
            end
            default: begin
              emits                = 1'b1;
              new_item.command     = lps_pkg::CMD_FADE;
              new_item.out_level   = 16'(e_level);
              new_item.fade_millis = e_dur;
              delay                = e_dur;
            end
          endcase
        end

        // A new command needs the pending one moved out first.
        hold = emits && pend_valid && !push_ready;
        if (!hold) begin
          push.valid = emits && pend_valid;
          if (emits) begin
            pend_item_next  = new_item;
            pend_valid_next = 1'b1;
          end
          if (at_end) begin
            active_length_next = '0;
            state_next         = S_FLUSH;
          end else if (at_limit) begin
            waiting_next        = 1'b1;
            wait_countdown_next = 16'd1;
            state_next          = pend_valid ? S_FLUSH : S_IDLE;
          end else begin
            done_count_next = done_count + DW'(1);
            position_next   = pos_inc;
            if (pos_inc == active_length && passes_left != '0) begin
              if (!passes_left[15]) begin
                passes_left_next = passes_left - 16'd1;
              end
              position_next = '0;
            end
            if (delay != '0) begin
              waiting_next        = 1'b1;
              wait_countdown_next = delay;
              state_next          = (emits || pend_valid) ? S_FLUSH : S_IDLE;
            end
          end
        end
      end

      S_FLUSH: begin
        // Last command of the request carries the last flag.
        push.valid     = 1'b1;
        push.item.last = 1'b1;
        if (push_ready) begin
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control and run registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      position       <= '0;
      active_length  <= '0;
      passes_left    <= '0;
      final_level    <= '0;
      wait_countdown <= '0;
      waiting        <= 1'b0;
      done_count     <= '0;
      pend_valid     <= 1'b0;
    end else begin
      state          <= state_next;
      position       <= position_next;
      active_length  <= active_length_next;
      passes_left    <= passes_left_next;
      final_level    <= final_level_next;
      wait_countdown <= wait_countdown_next;
      waiting        <= waiting_next;
      done_count     <= done_count_next;
      pend_valid     <= pend_valid_next;
    end
  end

  // Pending command payload.
  always_ff @(posedge clk) begin
    pend_item <= pend_item_next;
  end

`include "led_pattern_sequencer_core_defines.svh"

  `LPS_ASSERT_SAME(a_flush_has_cmd, clk, rst, state == S_FLUSH, pend_valid, "flush with no pending command")
  `LPS_ASSERT_NEXT(a_last_ends_req, clk, rst, push.valid && push_ready && push.item.last, state == S_IDLE && !pend_valid, "sequencer busy after last command")
  `LPS_ASSERT_SAME(a_wait_nonzero, clk, rst, waiting, wait_countdown != '0, "waiting with an expired countdown")
  `LPS_ASSERT_SAME(a_walk_bounded, clk, rst, state == S_WALK, 32'(done_count) <= WalkLimit, "walk went past its entry limit")

endmodule

// ===== tb/sv/lps_command_checker.sv =====
// Checker of the LED pattern sequencer: predicts the commands of each request and compares.
module lps_command_checker #(
  parameter int TableDepth = lps_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic           item_stall,
  input  lps_pkg::item_t item,
  input  logic           cmd_valid,
  input  logic           cmd_stall,
  input  lps_pkg::out_t  cmd,
  output int             fail_count,
  output int             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import lps_pkg::*;

  // Longest chain of entries without a delay in one step event.
  localparam int WalkLimit = (TableDepth < WALK_LIMIT_MAX) ? TableDepth : WALK_LIMIT_MAX;

  // Shadow of the step table and of the run registers.
  logic [1:0]  entry_kind  [TableDepth];
  logic [15:0] entry_level [TableDepth];
  logic [15:0] entry_millis[TableDepth];
  int unsigned walk_pos;
  int unsigned run_len;
  int          passes;
  logic [15:0] end_level;
  int unsigned countdown;
  bit          in_wait;

  out_t        expected_commands[$];
  int          batch_size;
  int          mismatches = 0;
  int          pending_count = 0;

  assign fail_count  = mismatches;
  assign outstanding = pending_count;

  task automatic clear_pattern();
    for (int i = 0; i < TableDepth; i++) begin
      entry_kind[i]   = KIND_SET;
      entry_level[i]  = '0;
      entry_millis[i] = '0;
    end
    walk_pos  = 0;
    run_len   = 0;
    passes    = 0;
    end_level = '0;
    countdown = 0;
    in_wait   = 1'b0;
    expected_commands.delete();
  endtask

  task automatic push_cmd(input logic code, input logic [15:0] level, input logic [15:0] millis);
    out_t entry;
    entry.command     = code;
    entry.out_level   = level;
    entry.fade_millis = millis;
    entry.last        = 1'b0;
    expected_commands = {expected_commands, entry};
    batch_size++;
  endtask

  // One step event: walk entries until a delay, the chain limit or the end of the run.
  task automatic walk_pattern();
    int unsigned visited;
    logic [15:0] delay;
    bit          running;
    visited = 0;
    running = 1'b1;
    while (running) begin
      if (walk_pos >= run_len) begin
        run_len = 0;
        push_cmd(CMD_SET, end_level, 16'd0);
        running = 1'b0;
      end else if (visited >= WalkLimit) begin
        in_wait   = 1'b1;
        countdown = 1;
        running   = 1'b0;
      end else begin
        delay = '0;
        case (entry_kind[walk_pos])
          KIND_SET: begin
            push_cmd(CMD_SET, entry_level[walk_pos], 16'd0);
          end
          KIND_HOLD: begin
            delay = entry_millis[walk_pos];
          end
          default: begin
            push_cmd(CMD_FADE, entry_level[walk_pos], entry_millis[walk_pos]);
            delay = entry_millis[walk_pos];
          end
        endcase
        visited++;
        walk_pos++;
        // Wrap for another pass; a negative count never runs out.
        if (walk_pos == run_len && passes != 0) begin
          if (passes > 0) passes--;
          walk_pos = 0;
        end
        if (delay != 0) begin
          in_wait   = 1'b1;
          countdown = delay;
          running   = 1'b0;
        end
      end
    end
  endtask

  // Work out the commands caused by one accepted request and queue them.
  task automatic predict_commands(input item_t req);
    batch_size = 0;
    case (req.operation)
      OP_LOAD: begin
        if (req.entry_index < TableDepth) begin
          entry_kind[req.entry_index]   = req.step_kind;
          entry_level[req.entry_index]  = req.step_level;
          entry_millis[req.entry_index] = req.step_duration;
        end
      end
      OP_START: begin
        run_len   = (req.run_length > TableDepth) ? TableDepth : req.run_length;
        passes    = req.extra_passes;
        end_level = req.final_level_in;
        walk_pos  = 0;
        if (run_len != 0 && !in_wait) walk_pattern();
        else push_cmd(CMD_SET, end_level, 16'd0);
      end
      OP_TICK: begin
        if (in_wait) begin
          if (countdown > 0) countdown--;
          if (countdown == 0) begin
            in_wait = 1'b0;
            walk_pattern();
          end
        end
      end
      default: ;
    endcase
    // Flag the final command of this request.
    if (batch_size != 0) begin
      expected_commands[expected_commands.size() - 1].last = 1'b1;
    end
  endtask

  // Watch both channels; requests are predicted before commands are compared.
  always @(posedge clk) begin : watch
    out_t want;
    if (rst) begin
      clear_pattern();
    end else begin
      if (item_valid && !item_stall) predict_commands(item);
      if (cmd_valid && !cmd_stall) begin
        if (expected_commands.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected command: cmd=%0d level=%h ms=%0d last=%0d",
                     cmd.command, cmd.out_level, cmd.fade_millis, cmd.last);
        end else begin
          want = expected_commands.pop_front();
          if (cmd.command !== want.command || cmd.out_level !== want.out_level ||
              cmd.fade_millis !== want.fade_millis || cmd.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("command mismatch: expected cmd=%0d level=%h ms=%0d last=%0d, %s",
                       want.command, want.out_level, want.fade_millis, want.last,
                       $sformatf("got cmd=%0d level=%h ms=%0d last=%0d",
                                 cmd.command, cmd.out_level, cmd.fade_millis, cmd.last));
          end
        end
      end
    end
    pending_count = expected_commands.size();
  end

endmodule

// ===== tb/sv/tb_led_pattern_sequencer_core.sv =====
// Testbench top of the LED pattern sequencer: clock, reset, request stimulus and verdict.
module tb_led_pattern_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lps_pkg::*;

  localparam int REQUEST_TARGET = 460;
  localparam int CYCLE_LIMIT    = 1_500_000;
  localparam int SETTLE_CYCLES  = 40;
  // Codes outside the documented set.
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  item_valid = 1'b0;
  logic  item_stall;
  item_t item = '0;
  logic  cmd_valid;
  logic  cmd_stall = 1'b0;
  out_t  cmd;
  int    fail_count;
  int    outstanding;
  bit    calm = 1'b0;
  int    stall_run = 0;
  int    sent = 0;

  always #2 clk = ~clk;

  led_pattern_sequencer_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd)
  );

  lps_command_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Pause length: mostly none, sometimes short, rarely long.
  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Hold and fade times stay short so that walks keep moving.
  function automatic logic [15:0] hold_time();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return 16'd0;
    if (roll < 9) return 16'($urandom_range(1, 4));
    return 16'($urandom_range(5, 24));
  endfunction

  function automatic logic [4:0] run_span();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 5'd0;
    if (roll == 1) return 5'($urandom_range(17, 31));
    return 5'($urandom_range(1, 16));
  endfunction

  function automatic logic [15:0] pass_count();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 12) return 16'($urandom_range(0, 2));
    if (roll < 15) return 16'hFFFF;
    if (roll < 16) return 16'h8000 | 16'($urandom);
    if (roll < 18) return 16'($urandom_range(3, 9));
    return 16'($urandom);
  endfunction

  // Every field random; builders below override the ones that matter.
  function automatic item_t random_request();
    item_t req;
    req.operation      = 2'($urandom_range(0, 3));
    req.entry_index    = 4'($urandom);
    req.step_kind      = 2'($urandom);
    req.step_level     = 16'($urandom);
    req.step_duration  = 16'($urandom);
    req.run_length     = 5'($urandom);
    req.extra_passes   = 16'($urandom);
    req.final_level_in = 16'($urandom);
    return req;
  endfunction

  function automatic item_t load_request(input logic [3:0] slot, input logic [1:0] kind,
                                         input logic [15:0] level, input logic [15:0] millis);
    item_t req;
    req               = random_request();
    req.operation     = OP_LOAD;
    req.entry_index   = slot;
    req.step_kind     = kind;
    req.step_level    = level;
    req.step_duration = millis;
    return req;
  endfunction

  // A set entry may carry any duration; a hold or fade gets a short one.
  function automatic item_t random_load();
    logic [1:0] kind;
    kind = 2'($urandom);
    return load_request(4'($urandom), kind, 16'($urandom),
                        (kind == KIND_SET) ? 16'($urandom) : hold_time());
  endfunction

  function automatic item_t start_request(input logic [4:0] span, input logic [15:0] extra,
                                          input logic [15:0] level);
    item_t req;
    req                = random_request();
    req.operation      = OP_START;
    req.run_length     = span;
    req.extra_passes   = extra;
    req.final_level_in = level;
    return req;
  endfunction

  function automatic item_t tick_request();
    item_t req;
    req           = random_request();
    req.operation = OP_TICK;
    return req;
  endfunction

  function automatic item_t noise_request();
    item_t req;
    req = random_request();
    if (req.operation == OP_LOAD) req = random_load();
    return req;
  endfunction

  // Offer one request after a random gap and hold it until accepted.
  task automatic send_request(input item_t req);
    int gap;
    gap = idle_length();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= req;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    if (req.operation != OP_UNUSED) sent++;
  endtask

  task automatic tick_burst(input int count);
    repeat (count) send_request(tick_request());
  endtask

  // Stop sending until every predicted command has come out.
  task automatic wait_for_commands();
    item_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // Command stall: stalled stretches of random length between short free stretches.
  always @(posedge clk) begin
    int span;
    if (rst || calm) begin
      cmd_stall <= 1'b0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if (cmd_stall) begin
      cmd_stall <= 1'b0;
      stall_run <= $urandom_range(0, 6);
    end else begin
      span = idle_length();
      if (span != 0) begin
        cmd_stall <= 1'b1;
        stall_run <= span - 1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int roll;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole table so that no walk reaches an unwritten entry.
    send_request(load_request(4'd0, KIND_SET, 16'h0000, 16'hFFFF));
    send_request(load_request(4'd1, KIND_SET, 16'hFFFF, 16'h0000));
    send_request(load_request(4'd2, KIND_FADE, 16'hFFFF, 16'd2));
    send_request(load_request(4'd3, KIND_HOLD, 16'h5A5A, 16'd1));
    send_request(load_request(4'd4, KIND_SPARE, 16'h1234, 16'd1));
    send_request(load_request(4'd5, KIND_FADE, 16'h00FF, 16'd0));
    for (int slot = 6; slot < 16; slot++)
      send_request(load_request(4'(slot), KIND_SET, 16'($urandom), 16'($urandom)));

    // Unknown operation, empty run, and a short run that ends in a fade.
    send_request(random_request() | {OP_UNUSED, 75'd0});
    send_request(start_request(5'd0, 16'd0, 16'hFFFF));
    send_request(start_request(5'd3, 16'd0, 16'h0000));
    // Start during a wait with an oversized length that repeats forever.
    send_request(start_request(5'd31, 16'hFFFF, 16'hAAAA));
    tick_burst(6);
    // Two set entries forever: the zero-delay chain limit hits on every event.
    send_request(start_request(5'd2, 16'h8000, 16'h5555));
    tick_burst(3);
    // Finite passes that end the run, then the largest pass count.
    send_request(start_request(5'd1, 16'd2, 16'h0F0F));
    tick_burst(1);
    send_request(start_request(5'd16, 16'h7FFF, 16'hC3C3));
    wait_for_commands();

    // Random programs: reload a few entries, start a run, tick; or noise, or drain.
    while (sent < REQUEST_TARGET) begin
      calm <= ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 19);
      if (roll < 15) begin
        repeat ($urandom_range(0, 4)) send_request(random_load());
        send_request(start_request(run_span(), pass_count(), 16'($urandom)));
        tick_burst($urandom_range(1, 16));
      end else if (roll < 19) begin
        repeat ($urandom_range(1, 6)) send_request(noise_request());
      end else begin
        wait_for_commands();
      end
    end

    calm <= 1'b0;
    wait_for_commands();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

endmodule
